[rtl/core/dqc_pkg.sv]
// ----------------------------------------------------------------------------
// dqc_pkg
// shared types, constants and the round-and-saturate helper of the dual
// quaternion conversion pipeline
// ----------------------------------------------------------------------------
package dqc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // exact four-term product sums
  localparam int SUM_W = 67;
  // divider numerator
  localparam int NUM_W = 68;
  // norm, up to 2^32
  localparam int NRM_W = 33;
  // pipeline depths of the root and divide units
  localparam int SQRT_LAT = 32;
  localparam int DIV_LAT  = 34;

  localparam logic [1:0] ACT_TQ_ENC   = 2'd0;
  localparam logic [1:0] ACT_QT_ENC   = 2'd1;
  localparam logic [1:0] ACT_UNIT_DEC = 2'd2;
  localparam logic [1:0] ACT_NORM_DEC = 2'd3;

  localparam logic [31:0] FIX_MAX = 32'h7fff_ffff;
  localparam logic [31:0] FIX_MIN = 32'h8000_0000;

  typedef logic signed [31:0] fix_t;

  typedef struct packed {
    logic ov;
    fix_t val;
  } sat_t;

  // round to nearest (ties up) after an arithmetic right shift, then clamp
  function automatic sat_t rnd_sat(input logic signed [SUM_W-1:0] v, input int unsigned sh);
    logic signed [SUM_W:0] s;
    sat_t r;
    s = (SUM_W+1)'(v) + ((SUM_W+1)'(1) <<< (sh - 1));
    s = s >>> sh;
    if (s[SUM_W:31] == '0 || s[SUM_W:31] == '1) begin
      r.ov  = 1'b0;
      r.val = s[31:0];
    end else begin
      r.ov  = 1'b1;
      r.val = s[SUM_W] ? FIX_MIN : FIX_MAX;
    end
    return r;
  endfunction

endpackage

[rtl/core/dqc_sqrt.sv]
// ----------------------------------------------------------------------------
// dqc_sqrt
// pipelined integer square root, one result digit per stage
// ----------------------------------------------------------------------------
module dqc_sqrt (
  input  logic                     clk,
  input  logic [64:0]              x,
  output logic [dqc_pkg::NRM_W-1:0] nrm
);
  import dqc_pkg::*;

  logic [33:0] rem_r  [SQRT_LAT];
  logic [31:0] root_r [SQRT_LAT];
  logic [63:0] xs_r   [SQRT_LAT];
  logic        hi_r   [SQRT_LAT];

  for (genvar i = 0; i < SQRT_LAT; i++) begin : g_step
    logic [33:0] rem_i;
    logic [31:0] root_i;
    logic [63:0] xs_i;
    logic        hi_i;
    logic [35:0] cur;
    logic [35:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign xs_i   = x[63:0];
      assign hi_i   = x[64];
    end else begin : g_next
      assign rem_i  = rem_r[i-1];
      assign root_i = root_r[i-1];
      assign xs_i   = xs_r[i-1];
      assign hi_i   = hi_r[i-1];
    end

    assign cur   = {rem_i, xs_i[63:62]};
    assign trial = {2'b00, root_i, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      rem_r[i]  <= ge ? 34'(cur - trial) : cur[33:0];
      root_r[i] <= {root_i[30:0], ge};
      xs_r[i]   <= {xs_i[61:0], 2'b00};
      hi_r[i]   <= hi_i;
    end
  end

  // a squared norm of exactly 2^64 has root 2^32
  assign nrm = hi_r[SQRT_LAT-1] ? {1'b1, 32'd0} : {1'b0, root_r[SQRT_LAT-1]};

endmodule

[rtl/core/dqc_div.sv]
// ----------------------------------------------------------------------------
// dqc_div
// pipelined rounding divider, one quotient bit per stage, saturated result
// ----------------------------------------------------------------------------
module dqc_div (
  input  logic                      clk,
  input  logic [dqc_pkg::NUM_W-1:0] n,
  input  logic                      neg,
  input  logic [dqc_pkg::NRM_W-1:0] d,
  output dqc_pkg::sat_t             res
);
  import dqc_pkg::*;

  localparam int QW = 32;

  logic [NUM_W-1:0] num;
  logic [NRM_W:0]   den;

  logic [33:0]    rem_r [QW+1];
  logic [QW-1:0]  lo_r  [QW+1];
  logic [NRM_W:0] den_r [QW+1];
  logic           neg_r [QW+1];
  logic           big_r [QW+1];
  sat_t           res_r;

  // rounding bias folded into the numerator
  assign num = (n << 1) + (neg ? NUM_W'(d - NRM_W'(1)) : NUM_W'(d));
  assign den = {d, 1'b0};

  always_ff @(posedge clk) begin
    rem_r[0] <= num[QW+33:QW];
    lo_r[0]  <= num[QW-1:0];
    den_r[0] <= den;
    neg_r[0] <= neg;
    big_r[0] <= (num[NUM_W-1:QW] >= (NUM_W-QW)'(den));
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [34:0] cur;
    logic        ge;

    assign cur = {rem_r[i], lo_r[i][QW-1]};
    assign ge  = (cur >= 35'(den_r[i]));

    always_ff @(posedge clk) begin
      rem_r[i+1] <= ge ? 34'(cur - 35'(den_r[i])) : cur[33:0];
      lo_r[i+1]  <= {lo_r[i][QW-2:0], ge};
      den_r[i+1] <= den_r[i];
      neg_r[i+1] <= neg_r[i];
      big_r[i+1] <= big_r[i];
    end
  end

  logic [QW-1:0] q;
  logic [QW-1:0] lim;
  logic          ovf;

  assign q   = lo_r[QW];
  assign lim = neg_r[QW] ? FIX_MIN : FIX_MAX;
  assign ovf = big_r[QW] || (q > lim);

  always_ff @(posedge clk) begin
    res_r.ov <= ovf;
    if (ovf) begin
      res_r.val <= neg_r[QW] ? FIX_MIN : FIX_MAX;
    end else begin
      res_r.val <= neg_r[QW] ? (~q + 32'd1) : q;
    end
  end

  assign res = res_r;

endmodule

[rtl/core/dual_quaternion_convert.sv]
// ----------------------------------------------------------------------------
// dual_quaternion_convert
// dual quaternion encode and decode unit, signed fixed point, fully pipelined
// ----------------------------------------------------------------------------
// all actions pass through the same pipeline to the out_valid strobe
// throughput: one item per cycle, busy stays low
// depth is set by the 32-stage root and the 34-stage divider of the normalizing decode
// reset clears the valid pipeline only, items in flight are dropped
// results cannot be held off and appear for exactly one cycle
// ----------------------------------------------------------------------------
module dual_quaternion_convert #(
  parameter int FRAC_BITS = dqc_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    in_action,
  input  dqc_pkg::fix_t in_a_w,
  input  dqc_pkg::fix_t in_a_x,
  input  dqc_pkg::fix_t in_a_y,
  input  dqc_pkg::fix_t in_a_z,
  input  dqc_pkg::fix_t in_b_w,
  input  dqc_pkg::fix_t in_b_x,
  input  dqc_pkg::fix_t in_b_y,
  input  dqc_pkg::fix_t in_b_z,
  output logic          out_valid,
  output dqc_pkg::fix_t out_r_w,
  output dqc_pkg::fix_t out_r_x,
  output dqc_pkg::fix_t out_r_y,
  output dqc_pkg::fix_t out_r_z,
  output dqc_pkg::fix_t out_s_w,
  output dqc_pkg::fix_t out_s_x,
  output dqc_pkg::fix_t out_s_y,
  output dqc_pkg::fix_t out_s_z,
  output logic          out_zero_norm,
  output logic          out_overflow
);
  import dqc_pkg::*;

  localparam int PAY_N = SQRT_LAT + DIV_LAT;

  typedef struct packed {
    logic [1:0]      act;
    logic            zn;
    logic            ov;
    fix_t [3:0]      r;
    fix_t [3:0]      s;
  } pay_t;

  typedef struct packed {
    logic [6:0][NUM_W-1:0] n;
    logic [6:0]            neg;
  } div_in_t;

  logic acc;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // stage 1: input register
  logic       v1_r;
  logic [1:0] act1_r;
  fix_t       a1_r [4];
  fix_t       b1_r [4];

  // stage 2: products
  logic              v2_r;
  logic [1:0]        act2_r;
  fix_t              a2_r [4];
  fix_t              b2_r [4];
  logic signed [63:0] p2_r [4][4];
  logic signed [63:0] sq2_r [4];

  // stage 3: sums
  logic                   v3_r;
  logic [1:0]             act3_r;
  fix_t                   a3_r [4];
  fix_t                   b3_r [4];
  logic signed [SUM_W-1:0] t3_r [4];
  logic [64:0]            n2_3_r;

  // stage 4: rounding and divider operands
  logic    v4_r;
  pay_t    p4_nxt, p4_r;
  div_in_t d4_nxt, d4_r;
  logic [64:0] n2_4_r;

  pay_t    pay_r [PAY_N];
  logic [PAY_N-1:0] pv_r;
  div_in_t dd_r [SQRT_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      pv_r <= '0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      pv_r <= {pv_r[PAY_N-2:0], v4_r};
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      act1_r  <= in_action;
      a1_r[0] <= in_a_w;
      a1_r[1] <= in_a_x;
      a1_r[2] <= in_a_y;
      a1_r[3] <= in_a_z;
      b1_r[0] <= in_b_w;
      b1_r[1] <= in_b_x;
      b1_r[2] <= in_b_y;
      b1_r[3] <= in_b_z;
    end
  end

  always_ff @(posedge clk) begin
    act2_r <= act1_r;
    a2_r   <= a1_r;
    b2_r   <= b1_r;
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 4; i++) begin
        p2_r[j][i] <= 64'(b1_r[j]) * 64'(a1_r[i]);
      end
      sq2_r[j] <= 64'(a1_r[j]) * 64'(a1_r[j]);
    end
  end

  // p2_r[b][a], index 0 w, 1 x, 2 y, 3 z
  logic signed [SUM_W-1:0] enc [4];
  logic signed [SUM_W-1:0] dec [1:3];

  always_comb begin
    enc[0] = -(SUM_W'(p2_r[1][1]) + SUM_W'(p2_r[2][2]) + SUM_W'(p2_r[3][3]));
    enc[1] =  SUM_W'(p2_r[1][0]) + SUM_W'(p2_r[2][3]) - SUM_W'(p2_r[3][2]);
    enc[2] = -SUM_W'(p2_r[1][3]) + SUM_W'(p2_r[2][0]) + SUM_W'(p2_r[3][1]);
    enc[3] =  SUM_W'(p2_r[1][2]) - SUM_W'(p2_r[2][1]) + SUM_W'(p2_r[3][0]);
    dec[1] = -SUM_W'(p2_r[0][1]) + SUM_W'(p2_r[1][0])
             - SUM_W'(p2_r[2][3]) + SUM_W'(p2_r[3][2]);
    dec[2] = -SUM_W'(p2_r[0][2]) + SUM_W'(p2_r[1][3])
             + SUM_W'(p2_r[2][0]) - SUM_W'(p2_r[3][1]);
    dec[3] = -SUM_W'(p2_r[0][3]) - SUM_W'(p2_r[1][2])
             + SUM_W'(p2_r[2][1]) + SUM_W'(p2_r[3][0]);
  end

  always_ff @(posedge clk) begin
    act3_r  <= act2_r;
    a3_r    <= a2_r;
    b3_r    <= b2_r;
    t3_r[0] <= enc[0];
    for (int k = 1; k < 4; k++) begin
      t3_r[k] <= (act2_r == ACT_TQ_ENC) ? enc[k] : dec[k];
    end
    n2_3_r <= 65'(sq2_r[0]) + 65'(sq2_r[1]) + 65'(sq2_r[2]) + 65'(sq2_r[3]);
  end

  sat_t enc_s [4];
  sat_t qt_s  [1:3];
  sat_t dec_s [1:3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      enc_s[k] = rnd_sat(t3_r[k], FRAC_BITS + 1);
    end
    for (int k = 1; k < 4; k++) begin
      qt_s[k]  = rnd_sat(SUM_W'(b3_r[k]), 1);
      dec_s[k] = rnd_sat(t3_r[k], FRAC_BITS - 1);
    end
  end

  always_comb begin
    logic [31:0]      am;
    logic [SUM_W-1:0] tm;
    p4_nxt     = '0;
    p4_nxt.act = act3_r;
    p4_nxt.zn  = (n2_3_r == '0);
    for (int k = 0; k < 4; k++) begin
      p4_nxt.r[k] = a3_r[k];
    end
    unique case (act3_r)
      ACT_TQ_ENC: begin
        for (int k = 0; k < 4; k++) begin
          p4_nxt.s[k] = enc_s[k].val;
          p4_nxt.ov   = p4_nxt.ov | enc_s[k].ov;
        end
      end
      ACT_QT_ENC: begin
        for (int k = 1; k < 4; k++) begin
          p4_nxt.s[k] = qt_s[k].val;
          p4_nxt.ov   = p4_nxt.ov | qt_s[k].ov;
        end
      end
      ACT_UNIT_DEC: begin
        for (int k = 1; k < 4; k++) begin
          p4_nxt.s[k] = dec_s[k].val;
          p4_nxt.ov   = p4_nxt.ov | dec_s[k].ov;
        end
      end
      ACT_NORM_DEC: begin
      end
    endcase

    d4_nxt = '0;
    for (int k = 0; k < 4; k++) begin
      am = a3_r[k][31] ? (~a3_r[k] + 32'd1) : a3_r[k];
      d4_nxt.n[k]   = NUM_W'(am) << FRAC_BITS;
      d4_nxt.neg[k] = a3_r[k][31];
    end
    for (int k = 1; k < 4; k++) begin
      tm = t3_r[k][SUM_W-1] ? (~t3_r[k] + SUM_W'(1)) : t3_r[k];
      d4_nxt.n[k+3]   = NUM_W'(tm) << 1;
      d4_nxt.neg[k+3] = t3_r[k][SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    p4_r   <= p4_nxt;
    d4_r   <= d4_nxt;
    n2_4_r <= n2_3_r;
  end

  always_ff @(posedge clk) begin
    pay_r[0] <= p4_r;
    for (int i = 1; i < PAY_N; i++) begin
      pay_r[i] <= pay_r[i-1];
    end
    dd_r[0] <= d4_r;
    for (int i = 1; i < SQRT_LAT; i++) begin
      dd_r[i] <= dd_r[i-1];
    end
  end

  logic [NRM_W-1:0] nrm;
  sat_t             dq [7];

  dqc_sqrt u_sqrt (
    .clk (clk),
    .x   (n2_4_r),
    .nrm (nrm)
  );

  for (genvar k = 0; k < 7; k++) begin : g_lane
    dqc_div u_div (
      .clk (clk),
      .n   (dd_r[SQRT_LAT-1].n[k]),
      .neg (dd_r[SQRT_LAT-1].neg[k]),
      .d   (nrm),
      .res (dq[k])
    );
  end

  pay_t       pe;
  fix_t [3:0] or_nxt, os_nxt, or_r, os_r;
  logic       zn_nxt, ov_nxt, zn_r, ov_r, out_valid_r;

  assign pe = pay_r[PAY_N-1];

  always_comb begin
    or_nxt = pe.r;
    os_nxt = pe.s;
    zn_nxt = 1'b0;
    ov_nxt = pe.ov;
    if (pe.act == ACT_NORM_DEC) begin
      if (pe.zn) begin
        or_nxt = '0;
        os_nxt = '0;
        zn_nxt = 1'b1;
        ov_nxt = 1'b0;
      end else begin
        ov_nxt    = 1'b0;
        os_nxt[0] = '0;
        for (int k = 0; k < 4; k++) begin
          or_nxt[k] = dq[k].val;
          ov_nxt    = ov_nxt | dq[k].ov;
        end
        for (int k = 1; k < 4; k++) begin
          os_nxt[k] = dq[k+3].val;
          ov_nxt    = ov_nxt | dq[k+3].ov;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pv_r[PAY_N-1];
    end
  end

  always_ff @(posedge clk) begin
    or_r <= or_nxt;
    os_r <= os_nxt;
    zn_r <= zn_nxt;
    ov_r <= ov_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_r_w       = or_r[0];
  assign out_r_x       = or_r[1];
  assign out_r_y       = or_r[2];
  assign out_r_z       = or_r[3];
  assign out_s_w       = os_r[0];
  assign out_s_x       = os_r[1];
  assign out_s_y       = os_r[2];
  assign out_s_z       = os_r[3];
  assign out_zero_norm = zn_r & out_valid_r;
  assign out_overflow  = ov_r & out_valid_r;

  a_zero_norm_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_zero_norm |-> !out_overflow && out_r_w == '0 && out_r_x == '0 && out_s_x == '0)
    else $error("zero norm item with nonzero fields");

  a_flags_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !out_zero_norm && !out_overflow)
    else $error("flags raised without an item");

  a_valid_trace: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v4_r, PAY_N + 1))
    else $error("item out without an item in the pipeline");

endmodule
